### rtl/rle_pkg.sv
// ============================================================================
// rle_pkg
// Shared types and constants of the leader-election node.
// ============================================================================
`default_nettype none

package rle_pkg;

    // Default parameter values.
    localparam int TERM_BITS_DEF = 32;
    localparam int ID_BITS_DEF   = 16;

    // Fixed field widths.
    localparam int CMD_BITS      = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int NODE_ID_BITS  = 16;
    localparam int CLUSTER_BITS  = 8;
    localparam int TIMEOUT_BITS  = 16;
    localparam int RND_BITS      = 16;
    localparam int ELECT_BITS    = 17;
    localparam int HB_BITS       = 16;
    localparam int VOTE_BITS     = 8;
    localparam int ROLE_BITS     = 2;

    // The timeout remainder is formed one dividend bit per cycle.
    localparam int DIV_STEPS     = RND_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    // Register reset values.
    localparam logic [NODE_ID_BITS-1:0] NODE_ID_RST  = NODE_ID_BITS'(0);
    localparam logic [CLUSTER_BITS-1:0] CLUSTER_RST  = CLUSTER_BITS'(3);
    localparam logic [TIMEOUT_BITS-1:0] ELECT_TO_RST = TIMEOUT_BITS'(150);
    localparam logic [TIMEOUT_BITS-1:0] HB_TO_RST    = TIMEOUT_BITS'(50);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK     = 3'd0,
        CMD_HB_REQ   = 3'd1,
        CMD_HB_RSP   = 3'd2,
        CMD_VOTE_REQ = 3'd3,
        CMD_VOTE_RSP = 3'd4
    } t_cmd;

    typedef enum logic [ROLE_BITS-1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } t_role;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NODE_ID      = 2'd0,
        CFG_CLUSTER_SIZE = 2'd1,
        CFG_ELECT_TO     = 2'd2,
        CFG_HB_TO        = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_COMMIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic div_last;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/raft_leader_election_fsm_unit.sv
// ============================================================================
// raft_leader_election_fsm_unit
// Leader-election node: role, term, vote and timers driven by ticks and
// heartbeat and vote messages, one result per transaction.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one tick or message per
//   transaction. Output channel (o_out_valid / i_out_ready) returns exactly
//   one result per input: reply fields, broadcast flags, role and term.
//   Configuration channel (i_cfg_valid / o_cfg_ready, index and data) writes
//   node id, cluster size, election timeout and heartbeat timeout; it is
//   always ready and must only be used while no transaction is in flight.
//   The random timeout draw runs a 16-step bit-serial remainder unit, one
//   step per cycle, on every transaction, followed by a commit. The input
//   is taken again right after the commit, while the previous result may
//   still wait.
//   Stall: if the output is not taken, the commit waits in place and the
//   input stays not ready until the result register frees up.
//   Reset (synchronous, active low): follower, term 0, no vote, timers 0,
//   configuration at its defaults, no result pending.
// ============================================================================
`default_nettype none

module raft_leader_election_fsm_unit #(
    parameter int TERM_BITS = rle_pkg::TERM_BITS_DEF,
    parameter int ID_BITS   = rle_pkg::ID_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [rle_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [rle_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [rle_pkg::CMD_BITS-1:0]        i_cmd,
    input  wire logic [TERM_BITS-1:0]                i_msg_term,
    input  wire logic [ID_BITS-1:0]                  i_candidate_id,
    input  wire logic                                i_granted_in,
    input  wire logic [rle_pkg::RND_BITS-1:0]        i_random_word,
    // Output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_reply_valid,
    output logic [TERM_BITS-1:0]                     o_reply_term,
    output logic                                     o_reply_ok,
    output logic                                     o_send_heartbeat,
    output logic                                     o_send_vote_request,
    output logic [rle_pkg::ROLE_BITS-1:0]            o_role,
    output logic [TERM_BITS-1:0]                     o_term_now
);

    rle_pkg::t_dp_cmd    w_ctl;
    rle_pkg::t_dp_status w_status;
    logic                w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    rle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_ctl)
    );

    rle_dp #(
        .TERM_BITS (TERM_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (w_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (i_cmd),
        .i_msg_term          (i_msg_term),
        .i_candidate_id      (i_candidate_id),
        .i_granted_in        (i_granted_in),
        .i_random_word       (i_random_word),
        .i_ctl               (w_ctl),
        .o_status            (w_status),
        .o_reply_valid       (o_reply_valid),
        .o_reply_term        (o_reply_term),
        .o_reply_ok          (o_reply_ok),
        .o_send_heartbeat    (o_send_heartbeat),
        .o_send_vote_request (o_send_vote_request),
        .o_role              (o_role),
        .o_term_now          (o_term_now)
    );

endmodule

`default_nettype wire

### rtl/rle_ctrl.sv
// ============================================================================
// rle_ctrl
// Sequencer: takes a transaction, runs the remainder unit, then commits the
// state update into the output register once that register is free.
// ============================================================================
`default_nettype none

module rle_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  rle_pkg::t_dp_status      i_status,
    output rle_pkg::t_dp_cmd         o_cmd
);

    rle_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_accept;
    logic            w_slot_free;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rle_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rle_pkg::S_DIVIDE;
            end
            rle_pkg::S_DIVIDE: begin
                if (i_status.div_last) n_state = rle_pkg::S_COMMIT;
            end
            rle_pkg::S_COMMIT: begin
                if (w_slot_free) n_state = rle_pkg::S_IDLE;
            end
            default: n_state = rle_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            rle_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rle_pkg::S_DIVIDE: begin
                o_cmd.step = 1'b1;
            end
            rle_pkg::S_COMMIT: begin
                o_cmd.commit = w_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rle_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    // A commit must never overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit overwrote a pending result");

    // An accepted transaction always starts the remainder unit.
    a_accept_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == rle_pkg::S_DIVIDE))
        else $error("accepted transaction did not start the divider");

    // A commit always leaves a valid result behind.
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("commit did not raise output valid");

    // The divider runs its full length before the commit.
    a_divide_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rle_pkg::S_DIVIDE && !i_status.div_last)
            |=> (r_state == rle_pkg::S_DIVIDE))
        else $error("divider left early");
`endif

endmodule

`default_nettype wire

### rtl/rle_dp.sv
// ============================================================================
// rle_dp
// Datapath: configuration registers, node state, the bit-serial remainder
// unit for the timeout draw, and the result register.
// ============================================================================
`default_nettype none

module rle_dp #(
    parameter int TERM_BITS = rle_pkg::TERM_BITS_DEF,
    parameter int ID_BITS   = rle_pkg::ID_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration writes
    input  wire logic                                i_cfg_valid,
    input  wire logic [rle_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [rle_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Input item
    input  wire logic [rle_pkg::CMD_BITS-1:0]        i_cmd,
    input  wire logic [TERM_BITS-1:0]                i_msg_term,
    input  wire logic [ID_BITS-1:0]                  i_candidate_id,
    input  wire logic                                i_granted_in,
    input  wire logic [rle_pkg::RND_BITS-1:0]        i_random_word,
    // Sequencer
    input  rle_pkg::t_dp_cmd                         i_ctl,
    output rle_pkg::t_dp_status                      o_status,
    // Result
    output logic                                     o_reply_valid,
    output logic [TERM_BITS-1:0]                     o_reply_term,
    output logic                                     o_reply_ok,
    output logic                                     o_send_heartbeat,
    output logic                                     o_send_vote_request,
    output logic [rle_pkg::ROLE_BITS-1:0]            o_role,
    output logic [TERM_BITS-1:0]                     o_term_now
);

    localparam logic [TERM_BITS-1:0] TermMax = {TERM_BITS{1'b1}};
    localparam logic [rle_pkg::ELECT_BITS-1:0] ElectMax = {rle_pkg::ELECT_BITS{1'b1}};
    localparam logic [rle_pkg::HB_BITS-1:0]    HbMax    = {rle_pkg::HB_BITS{1'b1}};
    localparam logic [rle_pkg::VOTE_BITS-1:0]  VoteMax  = {rle_pkg::VOTE_BITS{1'b1}};
    localparam logic [rle_pkg::DIV_CNT_BITS-1:0] DivLast =
        rle_pkg::DIV_CNT_BITS'(rle_pkg::DIV_STEPS - 1);

    // Configuration
    logic [rle_pkg::NODE_ID_BITS-1:0] r_node_id;
    logic [rle_pkg::CLUSTER_BITS-1:0] r_cluster_size;
    logic [rle_pkg::TIMEOUT_BITS-1:0] r_elect_to;
    logic [rle_pkg::TIMEOUT_BITS-1:0] r_hb_to;

    // Node state
    rle_pkg::t_role                  r_role, n_role;
    logic [TERM_BITS-1:0]            r_term, n_term;
    logic                            r_vote_valid, n_vote_valid;
    logic [ID_BITS-1:0]              r_voted_id, n_voted_id;
    logic [rle_pkg::VOTE_BITS-1:0]   r_votes, n_votes;
    logic [rle_pkg::ELECT_BITS-1:0]  r_elect_ticks, n_elect_ticks;
    logic [rle_pkg::ELECT_BITS-1:0]  r_drawn, n_drawn;
    logic [rle_pkg::HB_BITS-1:0]     r_hb_ticks, n_hb_ticks;

    // Latched item
    logic [rle_pkg::CMD_BITS-1:0]    r_cmd;
    logic [TERM_BITS-1:0]            r_mterm;
    logic [ID_BITS-1:0]              r_cand;
    logic                            r_granted;

    // Remainder unit
    logic [rle_pkg::RND_BITS-1:0]     r_div_sh;
    logic [rle_pkg::TIMEOUT_BITS-1:0] r_div_rem;
    logic [rle_pkg::DIV_CNT_BITS-1:0] r_div_cnt;
    logic [rle_pkg::TIMEOUT_BITS:0]   w_trial;
    logic [rle_pkg::TIMEOUT_BITS-1:0] w_rem_next;

    // Commit results
    logic                            n_rv, n_rok, n_shb, n_svr;
    logic [TERM_BITS-1:0]            n_rterm;
    logic [rle_pkg::TIMEOUT_BITS-1:0] w_extra;
    logic [rle_pkg::ELECT_BITS-1:0]  w_redraw;
    logic [rle_pkg::ELECT_BITS-1:0]  w_elect_inc;
    logic [rle_pkg::HB_BITS-1:0]     w_hb_inc;
    logic [rle_pkg::VOTE_BITS-1:0]   w_votes_inc;
    logic                            w_term_lt, w_term_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id      <= rle_pkg::NODE_ID_RST;
            r_cluster_size <= rle_pkg::CLUSTER_RST;
            r_elect_to     <= rle_pkg::ELECT_TO_RST;
            r_hb_to        <= rle_pkg::HB_TO_RST;
        end else if (i_cfg_valid) begin
            unique case (rle_pkg::t_cfg_idx'(i_cfg_index))
                rle_pkg::CFG_NODE_ID:      r_node_id      <= i_cfg_data;
                rle_pkg::CFG_CLUSTER_SIZE: r_cluster_size <= i_cfg_data[rle_pkg::CLUSTER_BITS-1:0];
                rle_pkg::CFG_ELECT_TO:     r_elect_to     <= i_cfg_data;
                rle_pkg::CFG_HB_TO:        r_hb_to        <= i_cfg_data;
                default:                   r_node_id      <= r_node_id;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_cmd;
            r_mterm   <= i_msg_term;
            r_cand    <= i_candidate_id;
            r_granted <= i_granted_in;
        end
    end

    // Restoring division, one dividend bit per cycle. For a nonzero divisor the
    // partial remainder stays below it, so the trial value fits one extra bit.
    assign w_trial    = {r_div_rem, r_div_sh[rle_pkg::RND_BITS-1]};
    assign w_rem_next = (w_trial >= {1'b0, r_elect_to})
                      ? rle_pkg::TIMEOUT_BITS'(w_trial - {1'b0, r_elect_to})
                      : w_trial[rle_pkg::TIMEOUT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_div_sh  <= i_random_word;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (i_ctl.step) begin
            r_div_sh  <= {r_div_sh[rle_pkg::RND_BITS-2:0], 1'b0};
            r_div_rem <= w_rem_next;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    assign o_status.div_last = (r_div_cnt == DivLast);

    assign w_extra     = (r_elect_to == '0) ? '0 : r_div_rem;
    assign w_redraw    = {1'b0, r_elect_to} + {1'b0, w_extra};
    assign w_elect_inc = (r_elect_ticks != ElectMax) ? r_elect_ticks + 1'b1 : r_elect_ticks;
    assign w_hb_inc    = (r_hb_ticks != HbMax) ? r_hb_ticks + 1'b1 : r_hb_ticks;
    assign w_votes_inc = (r_votes != VoteMax) ? r_votes + 1'b1 : r_votes;
    assign w_term_lt   = (r_term < r_mterm);
    assign w_term_eq   = (r_term == r_mterm);

    always_comb begin
        n_role        = r_role;
        n_term        = r_term;
        n_vote_valid  = r_vote_valid;
        n_voted_id    = r_voted_id;
        n_votes       = r_votes;
        n_elect_ticks = r_elect_ticks;
        n_drawn       = r_drawn;
        n_hb_ticks    = r_hb_ticks;
        n_rv          = 1'b0;
        n_rterm       = '0;
        n_rok         = 1'b0;
        n_shb         = 1'b0;
        n_svr         = 1'b0;
        unique case (r_cmd)
            rle_pkg::CMD_TICK: begin
                if (r_role == rle_pkg::ROLE_LEADER) begin
                    n_hb_ticks = w_hb_inc;
                    if (w_hb_inc >= r_hb_to) begin
                        n_hb_ticks = '0;
                        n_shb      = 1'b1;
                    end
                end else begin
                    n_elect_ticks = w_elect_inc;
                    if (w_elect_inc >= r_drawn) begin
                        if (r_role == rle_pkg::ROLE_FOLLOWER) begin
                            n_term       = (r_term != TermMax) ? r_term + 1'b1 : r_term;
                            n_vote_valid = 1'b1;
                            n_voted_id   = ID_BITS'(r_node_id);
                            n_votes      = rle_pkg::VOTE_BITS'(1);
                            n_role       = rle_pkg::ROLE_CANDIDATE;
                        end
                        n_elect_ticks = '0;
                        n_drawn       = w_redraw;
                        n_svr         = 1'b1;
                    end
                end
            end
            rle_pkg::CMD_HB_REQ: begin
                n_rv    = 1'b1;
                n_rterm = r_term;
                if (w_term_lt || w_term_eq) begin
                    n_rok         = 1'b1;
                    n_term        = r_mterm;
                    n_vote_valid  = 1'b0;
                    n_voted_id    = '0;
                    n_elect_ticks = '0;
                    n_drawn       = w_redraw;
                    n_role        = rle_pkg::ROLE_FOLLOWER;
                end
            end
            rle_pkg::CMD_HB_RSP: begin
                if (w_term_lt) begin
                    n_term        = r_mterm;
                    n_vote_valid  = 1'b0;
                    n_voted_id    = '0;
                    n_elect_ticks = '0;
                    n_drawn       = w_redraw;
                    n_role        = rle_pkg::ROLE_FOLLOWER;
                end
            end
            rle_pkg::CMD_VOTE_REQ: begin
                n_rv    = 1'b1;
                n_rterm = r_term;
                if (w_term_lt) begin
                    n_term        = r_mterm;
                    n_vote_valid  = 1'b1;
                    n_voted_id    = r_cand;
                    n_elect_ticks = '0;
                    n_drawn       = w_redraw;
                    n_role        = rle_pkg::ROLE_FOLLOWER;
                    n_rterm       = r_mterm;
                    n_rok         = 1'b1;
                end else if (w_term_eq && r_role == rle_pkg::ROLE_FOLLOWER
                             && !r_vote_valid) begin
                    n_vote_valid = 1'b1;
                    n_voted_id   = r_cand;
                    n_rok        = 1'b1;
                end
            end
            rle_pkg::CMD_VOTE_RSP: begin
                if (w_term_lt) begin
                    n_term        = r_mterm;
                    n_vote_valid  = 1'b0;
                    n_voted_id    = '0;
                    n_elect_ticks = '0;
                    n_drawn       = w_redraw;
                    n_role        = rle_pkg::ROLE_FOLLOWER;
                end else if (w_term_eq && r_role == rle_pkg::ROLE_CANDIDATE
                             && r_granted) begin
                    n_votes = w_votes_inc;
                    if (w_votes_inc > (r_cluster_size >> 1)) begin
                        n_role     = rle_pkg::ROLE_LEADER;
                        n_hb_ticks = '0;
                        n_shb      = 1'b1;
                    end
                end
            end
            default: begin
                n_rv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role        <= rle_pkg::ROLE_FOLLOWER;
            r_term        <= '0;
            r_vote_valid  <= 1'b0;
            r_voted_id    <= '0;
            r_votes       <= '0;
            r_elect_ticks <= '0;
            r_drawn       <= {1'b0, rle_pkg::ELECT_TO_RST};
            r_hb_ticks    <= '0;
        end else if (i_ctl.commit) begin
            r_role        <= n_role;
            r_term        <= n_term;
            r_vote_valid  <= n_vote_valid;
            r_voted_id    <= n_voted_id;
            r_votes       <= n_votes;
            r_elect_ticks <= n_elect_ticks;
            r_drawn       <= n_drawn;
            r_hb_ticks    <= n_hb_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            o_reply_valid       <= n_rv;
            o_reply_term        <= n_rterm;
            o_reply_ok          <= n_rok;
            o_send_heartbeat    <= n_shb;
            o_send_vote_request <= n_svr;
            o_role              <= n_role;
            o_term_now          <= n_term;
        end
    end

endmodule

`default_nettype wire

### tb/raft_leader_election_fsm_unit_test.sv
// ============================================================================
// raft_leader_election_fsm_unit_test
// Self-checking bench for the leader-election node. A short table of ticks
// and messages runs first, then randomized traffic across several settings
// of the four configuration registers, with gaps and back-pressure on both
// channels. Each result is compared field by field against the table's
// expected values or a behavioral model of the node held in the bench.
// ============================================================================
`default_nettype none

module raft_leader_election_fsm_unit_test;

    localparam int          HEAVY_PCT        = 78;
    localparam int          LIGHT_PCT        = 23;
    localparam int          ITEMS_PER_PHASE  = 48;
    localparam int          DRAIN_LIMIT      = 20000;
    localparam int          TAIL_CYCLES      = 40;
    localparam int          MAX_REPORTS      = 10;
    localparam logic [31:0] TERM_MAX         = '1;
    localparam logic [2:0]  CMD_UNDEF_LO     = 3'd5;
    localparam logic [2:0]  CMD_UNDEF_HI     = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] term;
        logic [15:0] cand;
        logic        granted;
        logic [15:0] rnd;
    } t_node_msg;

    typedef struct packed {
        logic        reply_valid;
        logic [31:0] reply_term;
        logic        reply_ok;
        logic        send_hb;
        logic        send_vr;
        logic [1:0]  role;
        logic [31:0] term_now;
    } t_node_result;

    typedef struct {
        logic              is_cfg;
        rle_pkg::t_cfg_idx cfg_idx;
        logic [15:0]       cfg_val;
        t_node_msg         msg;
        logic              known;
        t_node_result      want;
    } t_stim_row;

    typedef struct {
        logic [15:0] node_id;
        logic [15:0] cluster_word;
        logic [15:0] elect_to;
        logic [15:0] hb_to;
        int          sender_pct;
        int          receiver_pct;
    } t_cfg_phase;

    logic                              i_clk               = 1'b0;
    logic                              i_rst_n             = 1'b0;
    logic                              i_cfg_valid         = 1'b0;
    logic                              o_cfg_ready;
    logic [rle_pkg::CFG_IDX_BITS-1:0]  i_cfg_index         = '0;
    logic [rle_pkg::CFG_DATA_BITS-1:0] i_cfg_data          = '0;
    logic                              i_in_valid          = 1'b0;
    logic                              o_in_ready;
    logic [rle_pkg::CMD_BITS-1:0]      i_cmd               = '0;
    logic [31:0]                       i_msg_term          = '0;
    logic [15:0]                       i_candidate_id      = '0;
    logic                              i_granted_in        = 1'b0;
    logic [rle_pkg::RND_BITS-1:0]      i_random_word       = '0;
    logic                              o_out_valid;
    logic                              i_out_ready         = 1'b0;
    logic                              o_reply_valid;
    logic [31:0]                       o_reply_term;
    logic                              o_reply_ok;
    logic                              o_send_heartbeat;
    logic                              o_send_vote_request;
    logic [rle_pkg::ROLE_BITS-1:0]     o_role;
    logic [31:0]                       o_term_now;

    // Model copy of the node's configuration and state.
    logic [15:0]     cfg_node_id;
    logic [7:0]      cfg_cluster;
    logic [15:0]     cfg_elect_to;
    logic [15:0]     cfg_hb_to;
    rle_pkg::t_role  pr_role;
    logic [31:0]     pr_term;
    logic            pr_voted;
    logic [15:0]     pr_vote_id;
    logic [7:0]      pr_votes;
    logic [16:0]     pr_elect_ticks;
    logic [16:0]     pr_drawn;
    logic [15:0]     pr_hb_ticks;

    t_node_result expected_q[$];
    t_stim_row    rows[$];
    t_cfg_phase   phases[$];
    t_node_msg    next_msg;
    int           mismatch_count = 0;
    int           sender_pct     = 0;
    int           receiver_pct   = 0;

    raft_leader_election_fsm_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cmd               (i_cmd),
        .i_msg_term          (i_msg_term),
        .i_candidate_id      (i_candidate_id),
        .i_granted_in        (i_granted_in),
        .i_random_word       (i_random_word),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_reply_valid       (o_reply_valid),
        .o_reply_term        (o_reply_term),
        .o_reply_ok          (o_reply_ok),
        .o_send_heartbeat    (o_send_heartbeat),
        .o_send_vote_request (o_send_vote_request),
        .o_role              (o_role),
        .o_term_now          (o_term_now)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [16:0] draw_timeout(input logic [15:0] rnd);
        logic [15:0] extra;
        extra = (cfg_elect_to == '0) ? '0 : rnd % cfg_elect_to;
        return {1'b0, cfg_elect_to} + {1'b0, extra};
    endfunction

    task automatic step_down(input logic [31:0] term, input logic vote,
                             input logic [15:0] vote_id, input logic [15:0] rnd);
        pr_term        = term;
        pr_voted       = vote;
        pr_vote_id     = vote ? vote_id : '0;
        pr_elect_ticks = '0;
        pr_drawn       = draw_timeout(rnd);
        pr_role        = rle_pkg::ROLE_FOLLOWER;
    endtask

    // Advances the node model by one tick or message and returns its result.
    task automatic step_node(input t_node_msg m, output t_node_result r);
        r = '0;
        case (m.cmd)
            rle_pkg::CMD_TICK: begin
                if (pr_role == rle_pkg::ROLE_LEADER) begin
                    if (pr_hb_ticks != '1) pr_hb_ticks++;
                    if (pr_hb_ticks >= cfg_hb_to) begin
                        pr_hb_ticks = '0;
                        r.send_hb   = 1'b1;
                    end
                end else begin
                    if (pr_elect_ticks != '1) pr_elect_ticks++;
                    if (pr_elect_ticks >= pr_drawn) begin
                        // A candidate that times out re-broadcasts at the same term.
                        if (pr_role == rle_pkg::ROLE_FOLLOWER) begin
                            if (pr_term != TERM_MAX) pr_term++;
                            pr_voted   = 1'b1;
                            pr_vote_id = cfg_node_id;
                            pr_votes   = 8'd1;
                            pr_role    = rle_pkg::ROLE_CANDIDATE;
                        end
                        pr_elect_ticks = '0;
                        pr_drawn       = draw_timeout(m.rnd);
                        r.send_vr      = 1'b1;
                    end
                end
            end
            rle_pkg::CMD_HB_REQ: begin
                r.reply_valid = 1'b1;
                r.reply_term  = pr_term;
                if (pr_term <= m.term) begin
                    r.reply_ok = 1'b1;
                    step_down(m.term, 1'b0, '0, m.rnd);
                end
            end
            rle_pkg::CMD_HB_RSP: begin
                if (pr_term < m.term) step_down(m.term, 1'b0, '0, m.rnd);
            end
            rle_pkg::CMD_VOTE_REQ: begin
                r.reply_valid = 1'b1;
                r.reply_term  = pr_term;
                if (pr_term < m.term) begin
                    step_down(m.term, 1'b1, m.cand, m.rnd);
                    r.reply_term = m.term;
                    r.reply_ok   = 1'b1;
                end else if (pr_term == m.term && pr_role == rle_pkg::ROLE_FOLLOWER
                             && !pr_voted) begin
                    pr_voted   = 1'b1;
                    pr_vote_id = m.cand;
                    r.reply_ok = 1'b1;
                end
            end
            rle_pkg::CMD_VOTE_RSP: begin
                if (pr_term < m.term) begin
                    step_down(m.term, 1'b0, '0, m.rnd);
                end else if (pr_term == m.term && pr_role == rle_pkg::ROLE_CANDIDATE
                             && m.granted) begin
                    if (pr_votes != '1) pr_votes++;
                    if (pr_votes > (cfg_cluster >> 1)) begin
                        pr_role     = rle_pkg::ROLE_LEADER;
                        pr_hb_ticks = '0;
                        r.send_hb   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.role     = pr_role;
        r.term_now = pr_term;
    endtask

    function automatic t_stim_row known_row(input t_node_msg m, input t_node_result w);
        t_stim_row r;
        r.is_cfg  = 1'b0;
        r.cfg_idx = rle_pkg::CFG_NODE_ID;
        r.cfg_val = '0;
        r.msg     = m;
        r.known   = 1'b1;
        r.want    = w;
        return r;
    endfunction

    function automatic t_stim_row msg_row(input t_node_msg m);
        t_stim_row r;
        r       = known_row(m, '0);
        r.known = 1'b0;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input rle_pkg::t_cfg_idx idx,
                                          input logic [15:0] val);
        t_stim_row r;
        r         = msg_row('0);
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // Mostly traffic that follows the node's current term so that elections
    // complete, with some stale, jumping and garbage messages mixed in.
    function automatic t_node_msg random_msg();
        t_node_msg   m;
        int unsigned sel;
        int unsigned term_pick;
        sel       = $urandom_range(99);
        term_pick = $urandom_range(19);
        m.cand    = 16'($urandom);
        m.rnd     = 16'($urandom);
        m.granted = ($urandom_range(99) < 85);
        if (term_pick < 10)      m.term = pr_term;
        else if (term_pick < 14) m.term = (pr_term == TERM_MAX) ? pr_term : pr_term + 1;
        else if (term_pick < 16) m.term = pr_term - $urandom_range(3);
        else if (term_pick < 19) m.term = $urandom;
        else                     m.term = TERM_MAX - $urandom_range(2);
        if (sel < 45)      m.cmd = rle_pkg::CMD_TICK;
        else if (sel < 60) m.cmd = rle_pkg::CMD_VOTE_RSP;
        else if (sel < 70) m.cmd = rle_pkg::CMD_VOTE_REQ;
        else if (sel < 82) m.cmd = rle_pkg::CMD_HB_REQ;
        else if (sel < 92) m.cmd = rle_pkg::CMD_HB_RSP;
        else if (sel < 96) m.cmd = 3'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
        else begin
            m.cmd     = 3'($urandom_range(CMD_UNDEF_HI));
            m.term    = $urandom;
            m.granted = 1'($urandom);
        end
        return m;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // Called right at a clock edge; leaves valid high after the transaction so
    // that a following message can go out back to back.
    task automatic send_msg(input t_node_msg m, input logic known, input t_node_result want);
        t_node_result predicted;
        while ($urandom_range(99) < sender_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= m.cmd;
        i_msg_term     <= m.term;
        i_candidate_id <= m.cand;
        i_granted_in   <= m.granted;
        i_random_word  <= m.rnd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        step_node(m, predicted);
        expected_q.push_back(known ? want : predicted);
    endtask

    task automatic write_reg(input rle_pkg::t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            rle_pkg::CFG_NODE_ID:      cfg_node_id  = val;
            rle_pkg::CFG_CLUSTER_SIZE: cfg_cluster  = val[7:0];
            rle_pkg::CFG_ELECT_TO:     cfg_elect_to = val;
            rle_pkg::CFG_HB_TO:        cfg_hb_to    = val;
            default: begin
            end
        endcase
    endtask

    task automatic drain_results();
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (expected_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_node_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("term_now of a result with nothing outstanding", '0, o_term_now);
            end else begin
                want = expected_q.pop_front();
                if (o_reply_valid !== want.reply_valid)
                    report_mismatch("reply_valid", want.reply_valid, o_reply_valid);
                if (o_reply_term !== want.reply_term)
                    report_mismatch("reply_term", want.reply_term, o_reply_term);
                if (o_reply_ok !== want.reply_ok)
                    report_mismatch("reply_ok", want.reply_ok, o_reply_ok);
                if (o_send_heartbeat !== want.send_hb)
                    report_mismatch("send_heartbeat", want.send_hb, o_send_heartbeat);
                if (o_send_vote_request !== want.send_vr)
                    report_mismatch("send_vote_request", want.send_vr, o_send_vote_request);
                if (o_role !== want.role)
                    report_mismatch("role", want.role, o_role);
                if (o_term_now !== want.term_now)
                    report_mismatch("term_now", want.term_now, o_term_now);
            end
        end
        i_out_ready <= ($urandom_range(99) >= receiver_pct);
    end

    initial begin
        cfg_node_id    = rle_pkg::NODE_ID_RST;
        cfg_cluster    = rle_pkg::CLUSTER_RST;
        cfg_elect_to   = rle_pkg::ELECT_TO_RST;
        cfg_hb_to      = rle_pkg::HB_TO_RST;
        pr_role        = rle_pkg::ROLE_FOLLOWER;
        pr_term        = '0;
        pr_voted       = 1'b0;
        pr_vote_id     = '0;
        pr_votes       = '0;
        pr_elect_ticks = '0;
        pr_drawn       = {1'b0, rle_pkg::ELECT_TO_RST};
        pr_hb_ticks    = '0;

        // Reset defaults: node 0, three nodes, timeouts 150 and 50.
        rows.push_back(known_row('{rle_pkg::CMD_TICK, 32'd0, 16'd0, 1'b0, 16'd0},
            '{1'b0, 32'd0, 1'b0, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd0}));
        rows.push_back(known_row('{CMD_UNDEF_HI, TERM_MAX, 16'hFFFF, 1'b1, 16'hFFFF},
            '{1'b0, 32'd0, 1'b0, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd0}));
        rows.push_back(known_row('{CMD_UNDEF_LO, 32'd9, 16'd1, 1'b1, 16'd1},
            '{1'b0, 32'd0, 1'b0, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd0}));
        rows.push_back(known_row('{rle_pkg::CMD_VOTE_REQ, 32'd0, 16'h1234, 1'b0, 16'd0},
            '{1'b1, 32'd0, 1'b1, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd0}));
        rows.push_back(known_row('{rle_pkg::CMD_VOTE_REQ, 32'd0, 16'hFFFF, 1'b0, 16'd0},
            '{1'b1, 32'd0, 1'b0, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd0}));
        rows.push_back(known_row('{rle_pkg::CMD_HB_REQ, 32'd0, 16'd0, 1'b0, 16'hFFFF},
            '{1'b1, 32'd0, 1'b1, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd0}));
        rows.push_back(known_row('{rle_pkg::CMD_HB_RSP, 32'd5, 16'd0, 1'b0, 16'd3},
            '{1'b0, 32'd0, 1'b0, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd5}));
        // The heartbeat reply carries the term held before the message.
        rows.push_back(known_row('{rle_pkg::CMD_HB_REQ, 32'd3, 16'd0, 1'b0, 16'd0},
            '{1'b1, 32'd5, 1'b0, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd5}));
        rows.push_back(known_row('{rle_pkg::CMD_VOTE_REQ, 32'd5, 16'd7, 1'b0, 16'd0},
            '{1'b1, 32'd5, 1'b1, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd5}));
        rows.push_back(known_row('{rle_pkg::CMD_VOTE_REQ, 32'd6, 16'd9, 1'b0, 16'd77},
            '{1'b1, 32'd6, 1'b1, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd6}));
        rows.push_back(known_row('{rle_pkg::CMD_VOTE_RSP, 32'd6, 16'd0, 1'b1, 16'd0},
            '{1'b0, 32'd0, 1'b0, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, 32'd6}));
        rows.push_back(known_row('{rle_pkg::CMD_VOTE_RSP, TERM_MAX, 16'd0, 1'b0, 16'd0},
            '{1'b0, 32'd0, 1'b0, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, TERM_MAX}));
        rows.push_back(known_row('{rle_pkg::CMD_HB_REQ, TERM_MAX, 16'd0, 1'b0, 16'h8000},
            '{1'b1, TERM_MAX, 1'b1, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, TERM_MAX}));
        // With a zero election timeout the next redraw gives a zero deadline.
        rows.push_back(cfg_row(rle_pkg::CFG_ELECT_TO, 16'd0));
        rows.push_back(known_row('{rle_pkg::CMD_HB_REQ, TERM_MAX, 16'd0, 1'b0, 16'h5A5A},
            '{1'b1, TERM_MAX, 1'b1, 1'b0, 1'b0, rle_pkg::ROLE_FOLLOWER, TERM_MAX}));
        // Election at the largest term: the term stays saturated.
        rows.push_back(known_row('{rle_pkg::CMD_TICK, 32'd0, 16'd0, 1'b0, 16'h00FF},
            '{1'b0, 32'd0, 1'b0, 1'b0, 1'b1, rle_pkg::ROLE_CANDIDATE, TERM_MAX}));
        rows.push_back(known_row('{rle_pkg::CMD_TICK, 32'd0, 16'd0, 1'b0, 16'hFF00},
            '{1'b0, 32'd0, 1'b0, 1'b0, 1'b1, rle_pkg::ROLE_CANDIDATE, TERM_MAX}));
        rows.push_back(known_row('{rle_pkg::CMD_VOTE_RSP, TERM_MAX, 16'd0, 1'b1, 16'd0},
            '{1'b0, 32'd0, 1'b0, 1'b1, 1'b0, rle_pkg::ROLE_LEADER, TERM_MAX}));
        rows.push_back(msg_row('{rle_pkg::CMD_TICK, 32'd0, 16'd0, 1'b0, 16'd0}));
        rows.push_back(cfg_row(rle_pkg::CFG_HB_TO, 16'd1));
        rows.push_back(msg_row('{rle_pkg::CMD_TICK, 32'd0, 16'd0, 1'b0, 16'd0}));
        rows.push_back(msg_row('{rle_pkg::CMD_VOTE_REQ, TERM_MAX, 16'd3, 1'b0, 16'd0}));
        rows.push_back(msg_row('{rle_pkg::CMD_HB_RSP, TERM_MAX, 16'd0, 1'b0, 16'd0}));
        rows.push_back(msg_row('{rle_pkg::CMD_HB_REQ, 32'd0, 16'd0, 1'b0, 16'd0}));
        rows.push_back(msg_row('{rle_pkg::CMD_VOTE_RSP, 32'd1, 16'd0, 1'b1, 16'd0}));

        phases.push_back('{16'hFFFF, 16'h0003, 16'd4, 16'd3, 0, 0});
        phases.push_back('{16'h5A5A, 16'hFF01, 16'd1, 16'd1, HEAVY_PCT, 0});
        phases.push_back('{16'h0000, 16'h0000, 16'd0, 16'd0, 0, HEAVY_PCT});
        phases.push_back('{16'hA5A5, 16'h00FF, 16'hFFFF, 16'hFFFF, LIGHT_PCT, LIGHT_PCT});
        phases.push_back('{16'h1234, 16'hC305, 16'd3, 16'd2, LIGHT_PCT, LIGHT_PCT});
        phases.push_back('{16'($urandom), {8'($urandom), 8'($urandom_range(7, 1))},
            16'($urandom_range(10, 1)), 16'($urandom_range(6, 1)), 0, 0});
        phases.push_back('{16'($urandom), {8'($urandom), 8'($urandom_range(7, 1))},
            16'($urandom_range(10, 1)), 16'($urandom_range(6, 1)), HEAVY_PCT, 0});
        phases.push_back('{16'($urandom), {8'($urandom), 8'($urandom_range(7, 1))},
            16'($urandom_range(10, 1)), 16'($urandom_range(6, 1)), 0, HEAVY_PCT});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_pct   = LIGHT_PCT;
        receiver_pct = LIGHT_PCT;
        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                drain_results();
                write_reg(rows[k].cfg_idx, rows[k].cfg_val);
                i_cfg_valid <= 1'b0;
            end else begin
                send_msg(rows[k].msg, rows[k].known, rows[k].want);
            end
        end

        foreach (phases[p]) begin
            drain_results();
            write_reg(rle_pkg::CFG_NODE_ID, phases[p].node_id);
            write_reg(rle_pkg::CFG_CLUSTER_SIZE, phases[p].cluster_word);
            write_reg(rle_pkg::CFG_ELECT_TO, phases[p].elect_to);
            write_reg(rle_pkg::CFG_HB_TO, phases[p].hb_to);
            i_cfg_valid <= 1'b0;
            sender_pct   = phases[p].sender_pct;
            receiver_pct = phases[p].receiver_pct;
            repeat (ITEMS_PER_PHASE) begin
                next_msg = random_msg();
                send_msg(next_msg, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0d results never arrived", expected_q.size());
            mismatch_count += expected_q.size();
        end

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
